// ===== hw/rtl/pscfg_pkg.sv =====
// shared types and constants for the per-source connection flood guard
`default_nettype none
package pscfg_pkg;
    localparam int COUNT_BITS = 10;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_TRUST   = 2'd3;
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_LIFTED  = 2'd1;
    localparam logic [1:0] EV_IMPOSED = 2'd2;
    localparam logic [1:0] REG_MAXCONN = 2'd0;
    localparam logic [1:0] REG_BANTIME = 2'd1;
    localparam logic [1:0] REG_FLOOD   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] addr;
        logic [31:0] now;
    } t_item;
endpackage
`default_nettype wire

// ===== hw/rtl/per_source_connection_flood_guard.sv =====
// top level of the per-source connection flood guard
// Usage: one input transaction (opcode, source address, ms time) on the
// i_valid/o_ready channel gives one result transaction on o_valid/i_ready.
// A two-entry front queue takes transactions while the back end works; the
// back end searches the table one entry at a time (memory read, compare),
// stopping at the first match or after the last entry.
// The back end works on one item at a time and takes the next only when idle.
// The result is held in an output register until taken; a stalled receiver
// stops the back end, and the front queue fills and then drops o_ready.
// Reset (synchronous, active low) clears all entry valid bits at once and
// restores registers to 8, 60000 and 1000. The user writes them through APB
// at 0x0, 0x4 and 0x8 only while idle; the block does not enforce this.
`default_nettype none
module per_source_connection_flood_guard #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [31:0] i_source_addr,
    input  wire  [31:0] i_now_ms,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_allowed,
    output logic        o_found,
    output logic [1:0]  o_ban_event,
    output logic        o_table_full,
    output logic [9:0]  o_conn_count,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [9:0]  r_max_conn;
    logic [31:0] r_ban_time, r_flood;
    pscfg_pkg::t_item w_in, w_q;
    logic w_qv, w_qr;

    assign pready = 1'b1;
    assign w_in = '{opcode: i_opcode, addr: i_source_addr, now: i_now_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_conn <= 10'd8;
            r_ban_time <= 32'd60000;
            r_flood <= 32'd1000;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                pscfg_pkg::REG_MAXCONN: r_max_conn <= pwdata[9:0];
                pscfg_pkg::REG_BANTIME: r_ban_time <= pwdata;
                pscfg_pkg::REG_FLOOD: r_flood <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pscfg_pkg::REG_MAXCONN: prdata = {22'd0, r_max_conn};
            pscfg_pkg::REG_BANTIME: prdata = r_ban_time;
            pscfg_pkg::REG_FLOOD: prdata = r_flood;
            default: prdata = 32'd0;
        endcase
    end

    pscfg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    pscfg_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .i_max_conn(r_max_conn), .i_ban_time(r_ban_time), .i_flood(r_flood),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_allowed(o_allowed), .o_found(o_found), .o_ban_event(o_ban_event),
        .o_table_full(o_table_full), .o_conn_count(o_conn_count)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/pscfg_front.sv =====
// front end: input skid queue of two transactions
`default_nettype none
module pscfg_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  pscfg_pkg::t_item    i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output pscfg_pkg::t_item    o_item
);
    pscfg_pkg::t_item r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wp] <= i_item;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overflow");
    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
    a_pop_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 2'd1) else $error("pop count");
endmodule
`default_nettype wire

// ===== hw/rtl/pscfg_back.sv =====
// back end: sequential table search and read-modify-write
`default_nettype none
module pscfg_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  pscfg_pkg::t_item    i_item,
    input  wire  [9:0]          i_max_conn,
    input  wire  [31:0]         i_ban_time,
    input  wire  [31:0]         i_flood,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_allowed,
    output logic                o_found,
    output logic [1:0]          o_ban_event,
    output logic                o_table_full,
    output logic [9:0]          o_conn_count
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS = pscfg_pkg::COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_EXEC, S_OUT} t_state;

    logic [31:0]           m_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] m_cnt   [TABLE_ENTRIES];
    logic [31:0]           m_last  [TABLE_ENTRIES];
    logic [31:0]           m_bst   [TABLE_ENTRIES];
    logic                  m_ban   [TABLE_ENTRIES];
    logic                  m_tru   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;

    t_state            r_state;
    pscfg_pkg::t_item  r_it;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_hit, r_free;
    logic              r_hf, r_ff;
    logic [31:0]       r_rk;
    logic [COUNT_BITS-1:0] r_c;
    logic [31:0]       r_l, r_b;
    logic              r_bn, r_tr;
    logic              w_wr;
    logic [IW-1:0]     w_wi;
    logic              w_wv, w_nban, w_ntru;
    logic [COUNT_BITS-1:0] w_ncnt;
    logic [31:0]       w_nlast, w_nbst;
    logic              w_al, w_fd, w_fu;
    logic [1:0]        w_ev;
    logic [COUNT_BITS-1:0] w_oc;
    logic              w_den, w_lift, w_flood, w_cmp, w_bok;
    logic [COUNT_BITS-1:0] w_dec;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        w_bok  = (r_it.now - r_b) > i_ban_time;
        w_lift = r_bn && (r_tr || w_bok);
        w_den  = r_bn && !w_lift;
        w_flood = !w_den && !r_tr && (r_l != 32'd0) && ((r_it.now - r_l) < i_flood);
        w_cmp  = r_c >= i_max_conn;
        w_dec  = (r_c != '0) ? r_c - 1'b1 : r_c;
        w_wr = 1'b0; w_wi = r_hit; w_wv = 1'b1;
        w_ncnt = r_c; w_nlast = r_l; w_nbst = r_b; w_nban = r_bn; w_ntru = r_tr;
        w_al = 1'b0; w_fd = r_hf; w_fu = 1'b0; w_ev = pscfg_pkg::EV_NONE; w_oc = '0;
        case (r_it.opcode)
            pscfg_pkg::OP_CHECK: begin
                if (!r_hf) begin
                    w_al = (i_max_conn != 10'd0);
                end else begin
                    w_wr = 1'b1;
                    w_oc = r_c;
                    if (w_lift) begin
                        w_nban = 1'b0; w_nbst = '0; w_ev = pscfg_pkg::EV_LIFTED;
                    end
                    if (w_flood) begin
                        w_nban = 1'b1; w_nbst = r_it.now; w_ev = pscfg_pkg::EV_IMPOSED;
                    end else if (!w_den) begin
                        w_nlast = r_it.now;
                        if (w_cmp) begin
                            if (!r_tr) begin
                                w_nban = 1'b1; w_nbst = r_it.now;
                                w_ev = pscfg_pkg::EV_IMPOSED;
                            end
                        end else begin
                            w_al = 1'b1;
                        end
                    end
                end
            end
            pscfg_pkg::OP_INSERT: begin
                if (r_hf) begin
                    w_wr = 1'b1;
                    w_ncnt = (r_c != CMAX) ? r_c + 1'b1 : r_c;
                    w_oc = w_ncnt;
                end else if (!r_ff) begin
                    w_fu = 1'b1;
                end else begin
                    w_wr = 1'b1; w_wi = r_free;
                    w_ncnt = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                    w_nlast = r_it.now; w_nban = 1'b0; w_nbst = '0; w_ntru = 1'b0;
                    w_oc = w_ncnt;
                end
            end
            pscfg_pkg::OP_REMOVE: begin
                if (r_hf) begin
                    if (r_bn) begin
                        w_oc = r_c;
                    end else begin
                        w_wr = 1'b1; w_ncnt = w_dec;
                        w_wv = (w_dec != '0);
                        w_oc = w_dec;
                    end
                end
            end
            default: begin
                if (r_hf) begin
                    w_wr = 1'b1; w_ntru = 1'b1; w_oc = r_c;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it <= i_item;
                        r_idx <= '0;
                        r_hf <= 1'b0;
                        r_ff <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rk <= m_key[r_idx];
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (!r_hf && r_vld[r_idx] && r_rk == r_it.addr) begin
                        r_hf <= 1'b1; r_hit <= r_idx;
                    end
                    if (!r_ff && !r_vld[r_idx]) begin
                        r_ff <= 1'b1; r_free <= r_idx;
                    end
                    if (r_idx == IW'(TABLE_ENTRIES - 1) ||
                        (r_vld[r_idx] && r_rk == r_it.addr)) begin
                        r_state <= S_EXEC;
                        r_idx <= r_idx;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                    if (r_vld[r_idx] && r_rk == r_it.addr) begin
                        r_c <= m_cnt[r_idx];
                        r_l <= m_last[r_idx];
                        r_b <= m_bst[r_idx];
                        r_bn <= m_ban[r_idx];
                        r_tr <= m_tru[r_idx];
                    end
                end
                S_EXEC: begin
                    if (w_wr) begin
                        m_key[w_wi] <= r_it.addr;
                        m_cnt[w_wi] <= w_ncnt;
                        m_last[w_wi] <= w_nlast;
                        m_bst[w_wi] <= w_nbst;
                        m_ban[w_wi] <= w_nban;
                        m_tru[w_wi] <= w_ntru;
                        r_vld[w_wi] <= w_wv;
                    end
                    o_allowed <= w_al;
                    o_found <= w_fd;
                    o_ban_event <= w_ev;
                    o_table_full <= w_fu;
                    o_conn_count <= 10'(w_oc);
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_lift_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ban_event != pscfg_pkg::EV_NONE) |-> o_found)
        else $error("ban event without entry");
    a_full_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_found && o_conn_count == 10'd0))
        else $error("full with entry");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the per-source connection flood guard: scoreboard class, drivers, checks
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;
    localparam logic [9:0] COUNT_TOP = 10'h3FF;

    typedef struct packed {
        logic       allowed;
        logic       found;
        logic [1:0] ban_event;
        logic       table_full;
        logic [9:0] conn_count;
    } t_verdict;

    class guard_scoreboard;
        logic [9:0]  max_conn;
        logic [31:0] ban_time;
        logic [31:0] flood_win;
        bit          valid_q[ENTRIES];
        logic [31:0] key_q[ENTRIES];
        logic [9:0]  count_q[ENTRIES];
        logic [31:0] last_chk[ENTRIES];
        bit          banned_q[ENTRIES];
        logic [31:0] ban_start[ENTRIES];
        bit          trusted_q[ENTRIES];
        t_verdict    pending[$];
        int          mismatches;
        int          results_seen;
        int          bans_seen;
        int          lifts_seen;
        int          fulls_seen;

        function void clear();
            max_conn = 10'd8;
            ban_time = 32'd60000;
            flood_win = 32'd1000;
            foreach (valid_q[i]) valid_q[i] = 0;
            pending.delete();
            mismatches = 0;
            results_seen = 0;
            bans_seen = 0;
            lifts_seen = 0;
            fulls_seen = 0;
        endfunction

        function int lookup(logic [31:0] k);
            for (int i = 0; i < ENTRIES; i++)
                if (valid_q[i] && key_q[i] == k) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < ENTRIES; i++)
                if (!valid_q[i]) return i;
            return -1;
        endfunction

        function void note_item(logic [1:0] op, logic [31:0] k, logic [31:0] now);
            t_verdict v;
            int e;
            int f;
            bit denied;
            v = '0;
            e = lookup(k);
            v.found = (e >= 0);
            case (op)
                pscfg_pkg::OP_CHECK: begin
                    if (e < 0) begin
                        v.allowed = (max_conn != 0);
                    end else begin
                        denied = 0;
                        if (banned_q[e]) begin
                            if (trusted_q[e] || (now - ban_start[e]) > ban_time) begin
                                banned_q[e] = 0;
                                ban_start[e] = 0;
                                v.ban_event = pscfg_pkg::EV_LIFTED;
                            end else begin
                                denied = 1;
                            end
                        end
                        if (!denied && !trusted_q[e] && last_chk[e] != 0 &&
                            (now - last_chk[e]) < flood_win) begin
                            banned_q[e] = 1;
                            ban_start[e] = now;
                            v.ban_event = pscfg_pkg::EV_IMPOSED;
                            denied = 1;
                        end
                        if (!denied) begin
                            last_chk[e] = now;
                            if (count_q[e] >= max_conn) begin
                                if (!trusted_q[e]) begin
                                    banned_q[e] = 1;
                                    ban_start[e] = now;
                                    v.ban_event = pscfg_pkg::EV_IMPOSED;
                                end
                            end else begin
                                v.allowed = 1;
                            end
                        end
                        v.conn_count = count_q[e];
                    end
                end
                pscfg_pkg::OP_INSERT: begin
                    if (e >= 0) begin
                        if (count_q[e] < COUNT_TOP) count_q[e]++;
                        v.conn_count = count_q[e];
                    end else begin
                        f = free_slot();
                        if (f < 0) begin
                            v.table_full = 1;
                        end else begin
                            valid_q[f] = 1;
                            key_q[f] = k;
                            count_q[f] = 1;
                            last_chk[f] = now;
                            banned_q[f] = 0;
                            ban_start[f] = 0;
                            trusted_q[f] = 0;
                            v.conn_count = 1;
                        end
                    end
                end
                pscfg_pkg::OP_REMOVE: begin
                    if (e >= 0) begin
                        if (!banned_q[e]) begin
                            if (count_q[e] > 0) count_q[e]--;
                            if (count_q[e] == 0) valid_q[e] = 0;
                        end
                        v.conn_count = valid_q[e] ? count_q[e] : 10'd0;
                    end
                end
                default: begin
                    if (e >= 0) begin
                        trusted_q[e] = 1;
                        v.conn_count = count_q[e];
                    end
                end
            endcase
            pending.push_back(v);
        endfunction

        function void check_result(t_verdict got);
            t_verdict exp_v;
            results_seen++;
            if (got.ban_event == pscfg_pkg::EV_IMPOSED) bans_seen++;
            if (got.ban_event == pscfg_pkg::EV_LIFTED) lifts_seen++;
            if (got.table_full) fulls_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %p", got);
                return;
            end
            exp_v = pending.pop_front();
            if (got !== exp_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", exp_v, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [31:0] i_source_addr;
    logic [31:0] i_now_ms;
    logic        o_valid;
    logic        i_ready;
    logic        o_allowed;
    logic        o_found;
    logic [1:0]  o_ban_event;
    logic        o_table_full;
    logic [9:0]  o_conn_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    per_source_connection_flood_guard uut (.*);

    guard_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int items_sent;
    logic [31:0] clock_ms;
    logic [31:0] addr_pool[16];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("** per_source_connection_flood_guard: FAILED **");
        $finish;
    end

    initial begin
        i_ready = 0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid)
                sb.check_result({o_allowed, o_found, o_ban_event, o_table_full,
                                 o_conn_count});
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        penable <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            pscfg_pkg::REG_MAXCONN: sb.max_conn = val[9:0];
            pscfg_pkg::REG_BANTIME: sb.ban_time = val;
            default: sb.flood_win = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send(logic [1:0] op, logic [31:0] k, logic [31:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_source_addr <= k;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(op, k, now);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (140) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [1:0] op;
        logic [31:0] k;
        int r;
        r = $urandom_range(99);
        op = (r < 35) ? pscfg_pkg::OP_INSERT : (r < 65) ? pscfg_pkg::OP_CHECK :
             (r < 88) ? pscfg_pkg::OP_REMOVE : pscfg_pkg::OP_TRUST;
        k = ($urandom_range(9) == 0) ? $urandom() : addr_pool[$urandom_range(15)];
        case ($urandom_range(3))
            0: clock_ms = clock_ms + $urandom_range(5);
            1: clock_ms = clock_ms + $urandom_range(3000);
            2: clock_ms = clock_ms + $urandom_range(200000);
            default: clock_ms = $urandom();
        endcase
        send(op, k, clock_ms);
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 0;
        i_valid = 0;
        i_opcode = '0;
        i_source_addr = '0;
        i_now_ms = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        items_sent = 0;
        clock_ms = 32'd5000;
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send(pscfg_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0);
        send(pscfg_pkg::OP_REMOVE, 32'h0A00_0001, 32'd1);
        send(pscfg_pkg::OP_TRUST, 32'h0A00_0001, 32'd1);
        send(pscfg_pkg::OP_INSERT, 32'h0A00_0001, 32'd100);
        send(pscfg_pkg::OP_CHECK, 32'h0A00_0001, 32'd500);
        send(pscfg_pkg::OP_CHECK, 32'h0A00_0001, 32'd30000);
        send(pscfg_pkg::OP_CHECK, 32'h0A00_0001, 32'd70000);
        send(pscfg_pkg::OP_CHECK, 32'h0A00_0001, 32'd70001);
        send(pscfg_pkg::OP_REMOVE, 32'h0A00_0001, 32'd70002);
        send(pscfg_pkg::OP_TRUST, 32'h0A00_0001, 32'd70003);
        send(pscfg_pkg::OP_CHECK, 32'h0A00_0001, 32'd70004);
        send(pscfg_pkg::OP_REMOVE, 32'h0A00_0001, 32'd70005);
        send(pscfg_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send(pscfg_pkg::OP_CHECK, 32'h0, 32'd0);
        send(pscfg_pkg::OP_CHECK, 32'h0, 32'd10);
        send(pscfg_pkg::OP_INSERT, 32'h0, 32'd20);
        send(pscfg_pkg::OP_CHECK, 32'h0, 32'd100000);
        send(pscfg_pkg::OP_REMOVE, 32'h0, 32'd100001);
        drain();
        write_reg(pscfg_pkg::REG_MAXCONN, 32'd0);
        write_reg(pscfg_pkg::REG_FLOOD, 32'd0);
        write_reg(pscfg_pkg::REG_BANTIME, 32'hFFFF_FFFF);
        send(pscfg_pkg::OP_CHECK, 32'h1234_5678, 32'd5);
        send(pscfg_pkg::OP_INSERT, 32'h1234_5678, 32'd5);
        send(pscfg_pkg::OP_CHECK, 32'h1234_5678, 32'd6);
        send(pscfg_pkg::OP_CHECK, 32'h1234_5678, 32'd7);
        send(pscfg_pkg::OP_TRUST, 32'h1234_5678, 32'd8);
        send(pscfg_pkg::OP_CHECK, 32'h1234_5678, 32'd9);
        drain();

        // fill the table past full
        write_reg(pscfg_pkg::REG_MAXCONN, 32'd1023);
        write_reg(pscfg_pkg::REG_FLOOD, 32'd1000);
        write_reg(pscfg_pkg::REG_BANTIME, 32'd60000);
        for (int i = 0; i < ENTRIES + 2; i++)
            send(pscfg_pkg::OP_INSERT, 32'hC0A8_0000 + i, clock_ms + i);
        drain();
        // remove each filled address once while the receiver holds off
        hold_off = 300;
        for (int i = 0; i < ENTRIES; i++)
            send(pscfg_pkg::OP_REMOVE, 32'hC0A8_0000 + i, 32'd2);
        drain();

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 10; end
            endcase
            case (ph)
                0: write_reg(pscfg_pkg::REG_MAXCONN, 32'd3);
                1: write_reg(pscfg_pkg::REG_FLOOD, 32'hFFFF_FFFF);
                2: write_reg(pscfg_pkg::REG_BANTIME, 32'd0);
                3: begin
                    write_reg(pscfg_pkg::REG_MAXCONN, 32'd1);
                    write_reg(pscfg_pkg::REG_FLOOD, 32'd2000);
                    write_reg(pscfg_pkg::REG_BANTIME, 32'd5000);
                end
                default: write_reg(pscfg_pkg::REG_MAXCONN, 32'd8);
            endcase
            if (ph == 4) hold_off = 400;
            for (int n = 0; n < 60; n++) random_item();
            drain();
        end

        $display("ran %0d transactions, %0d results: %0d bans, %0d lifts, %0d table full",
                 items_sent, sb.results_seen, sb.bans_seen, sb.lifts_seen, sb.fulls_seen);
        $display("covered all opcodes, register extremes and four idling phases");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("** per_source_connection_flood_guard: PASSED **");
        end else begin
            $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
            $display("** per_source_connection_flood_guard: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
